// ===== rtl/chb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chb_pkg: shared types and codes of the sorted-bucket hash store
// Holds the command and status codes, the field widths of the request and
// result items, and the operation record that the front hands to the back.
// ----------------------------------------------------------------------------
package chb_pkg;

  // Field widths fixed by the item format.
  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 31;
  localparam int SEL_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int STAT_W     = 2;
  localparam int FILL_OUT_W = 4;
  localparam int CFG_W      = 5;

  // An insert's bucket index is below the live bucket count; every bucket index fits the register width.
  localparam int BKT_W = CFG_W;

  // Default geometry of the store.
  localparam int BUCKETS_DEF = 16;
  localparam int SLOTS_DEF   = 8;

  // Reset value of the bucket count register.
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 5'd16;

  // Entries in the queue between front and back.
  localparam int QDEPTH = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One request item.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [SEL_W-1:0]   bucket_sel;
    logic [SLOT_W-1:0]  slot_sel;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [VALUE_W-1:0]    result_value;
    logic [SEL_W-1:0]      result_bucket;
    logic [SLOT_W-1:0]     result_slot;
    logic [FILL_OUT_W-1:0] bucket_fill;
  } out_item_t;

  // A classified operation, queued from front to back.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [BKT_W-1:0]   bucket;
    logic [SLOT_W-1:0]  slot;
    logic               miss;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/chb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chb_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module chb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/chb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chb_queue: operation queue between front and back
// A short first-in first-out buffer of classified operations.
// ----------------------------------------------------------------------------
module chb_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  chb_pkg::op_t din,
  output logic        full,
  input  logic        pop,
  output chb_pkg::op_t dout,
  output logic        empty
);

  import chb_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW  = $clog2(QDEPTH + 1);

  op_t            entries [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/chb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chb_front: command intake and bucket hashing
// Accepts one item, reduces an insert value modulo the live bucket count with a
// four-bit-per-cycle remainder unit, and queues the classified operation.
// ----------------------------------------------------------------------------
module chb_front #(
  parameter int BUCKETS = chb_pkg::BUCKETS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  chb_pkg::in_item_t         request,
  input  logic [chb_pkg::CFG_W-1:0] bucket_count,
  output logic                      busy,
  output logic                      q_push,
  output chb_pkg::op_t              q_op,
  input  logic                      q_full
);

  import chb_pkg::*;

  localparam int DIGIT     = 4;
  localparam int DIV_W     = ((VALUE_W + DIGIT - 1) / DIGIT) * DIGIT;
  localparam int DIV_STEPS = DIV_W / DIGIT;
  localparam int SCW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state;
  op_t              op;
  logic [DIV_W-1:0] work;
  logic [BKT_W-1:0] rem;
  logic [BKT_W-1:0] divisor;
  logic [SCW-1:0]   step_cnt;
  logic [BKT_W-1:0] rem_next;
  logic [BKT_W-1:0] live;
  logic             accept;

  assign busy   = (state != F_IDLE);
  assign accept = start && (state == F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_op   = op;

  // Live bucket count: zero acts as one, and it saturates at the store size.
  always_comb begin
    if (bucket_count == '0) begin
      live = BKT_W'(1);
    end else if (int'(bucket_count) > BUCKETS) begin
      live = BKT_W'(BUCKETS);
    end else begin
      live = bucket_count;
    end
  end

  // One digit of restoring remainder: four conditional subtracts on narrow values.
  always_comb begin
    logic [BKT_W:0]   t;
    logic [BKT_W-1:0] r;
    r = rem;
    t = '0;
    for (int k = 0; k < DIGIT; k++) begin
      t = {r, work[DIV_W-1-k]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[BKT_W-1:0];
    end
    rem_next = r;
  end

  // Intake sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= (request.cmd == CMD_INSERT) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (step_cnt == SCW'(DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Operation record and remainder datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      op.cmd    <= request.cmd;
      op.value  <= request.value;
      op.bucket <= BKT_W'(request.bucket_sel);
      op.slot   <= request.slot_sel;
      op.miss   <= (int'(request.bucket_sel) >= BUCKETS);
      work      <= DIV_W'(request.value);
      rem       <= '0;
      divisor   <= live;
      step_cnt  <= '0;
    end else if (state == F_DIV) begin
      work     <= work << DIGIT;
      rem      <= rem_next;
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == SCW'(DIV_STEPS - 1)) begin
        op.bucket <= rem_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The front only frees itself by handing its operation to the queue.
  a_release_on_push: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(q_push))
    else $error("front went idle without queuing its item");
`endif

endmodule

`default_nettype wire

// ===== rtl/chb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chb_back: bucket store and command execution
// Holds the slot RAM and the fill-count RAM with per-bucket valid bits, runs
// reads, clears and sorted inserts (a top-down shift, one slot per cycle), and
// drives the result strobe.
// ----------------------------------------------------------------------------
module chb_back #(
  parameter int BUCKETS = chb_pkg::BUCKETS_DEF,
  parameter int SLOTS   = chb_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  chb_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               done,
  output chb_pkg::out_item_t result
);

  import chb_pkg::*;

  localparam int BKT_AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOT_DEPTH = BUCKETS * SLOTS;
  localparam int RAM_AW     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int FW         = $clog2(SLOTS + 1);
  localparam int CMPW       = FW + SLOT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLOOK = 3'd1;
  localparam logic [2:0] S_FCHK  = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;

  logic [2:0]         state;
  op_t                cur;
  logic [FW-1:0]      idx;
  logic [FW-1:0]      nfill;
  logic [BUCKETS-1:0] fvalid;

  logic [BKT_AW-1:0]  bkt;
  logic [RAM_AW-1:0]  base;
  logic [FW-1:0]      fill_now;
  logic               greater;
  logic               slot_out;

  logic               s_we;
  logic [RAM_AW-1:0]  s_waddr;
  logic [VALUE_W-1:0] s_wdata;
  logic [RAM_AW-1:0]  s_raddr;
  logic [VALUE_W-1:0] s_rd;

  logic               f_we;
  logic [FW-1:0]      f_wdata;
  logic [FW-1:0]      f_rd;

  function automatic out_item_t make_res(
    input logic [STAT_W-1:0]     st,
    input logic [VALUE_W-1:0]    v,
    input logic [BKT_W-1:0]      b,
    input logic [SLOT_W-1:0]     s,
    input logic [FILL_OUT_W-1:0] f
  );
    out_item_t r;
    r.status        = st;
    r.result_value  = v;
    r.result_bucket = SEL_W'(b);
    r.result_slot   = s;
    r.bucket_fill   = f;
    return r;
  endfunction

  // Row addressing and the bucket's current fill.
  assign bkt      = BKT_AW'(cur.bucket);
  assign base     = RAM_AW'(bkt * SLOTS);
  assign fill_now = fvalid[bkt] ? f_rd : '0;
  assign greater  = (cur.value > s_rd);
  assign slot_out = (CMPW'(cur.slot) >= CMPW'(fill_now)) ||
                    (CMPW'(cur.slot) >= CMPW'(SLOTS));
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // Slot RAM port control.
  always_comb begin
    s_we    = 1'b0;
    s_waddr = base + RAM_AW'(idx);
    s_wdata = cur.value;
    s_raddr = base + RAM_AW'(cur.slot);
    unique case (state)
      S_FCHK: begin
        if (cur.cmd == CMD_INSERT && fill_now != FW'(SLOTS)) begin
          if (fill_now == '0) begin
            s_we    = 1'b1;
            s_waddr = base;
          end else begin
            s_raddr = base + RAM_AW'(fill_now - FW'(1));
          end
        end
      end
      S_SHIFT: begin
        s_we    = 1'b1;
        s_wdata = greater ? cur.value : s_rd;
        s_raddr = base + RAM_AW'(idx - FW'(2));
      end
      S_PLACE: begin
        s_we    = 1'b1;
        s_waddr = base;
      end
      default: begin
      end
    endcase
  end

  // Fill RAM is updated once per accepted insert.
  assign f_we    = (state == S_FCHK) && (cur.cmd == CMD_INSERT) && (fill_now != FW'(SLOTS));
  assign f_wdata = fill_now + FW'(1);

  chb_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rd)
  );

  chb_ram #(
    .WIDTH (FW),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (bkt),
    .wdata (f_wdata),
    .raddr (bkt),
    .rdata (f_rd)
  );

  // Execution sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      fvalid <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_op;
            unique case (q_op.cmd)
              CMD_INSERT: begin
                state <= S_FLOOK;
              end
              CMD_READ: begin
                if (q_op.miss) begin
                  done   <= 1'b1;
                  result <= make_res(ST_EMPTY, '0, q_op.bucket, q_op.slot, '0);
                end else begin
                  state <= S_FLOOK;
                end
              end
              CMD_CLEAR: begin
                fvalid <= '0;
                done   <= 1'b1;
                result <= make_res(ST_DONE, '0, '0, '0, '0);
              end
              default: begin
                done   <= 1'b1;
                result <= make_res(ST_DONE, '0, '0, '0, '0);
              end
            endcase
          end
        end
        S_FLOOK: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (cur.cmd == CMD_INSERT) begin
            if (fill_now == FW'(SLOTS)) begin
              done   <= 1'b1;
              result <= make_res(ST_FULL, '0, cur.bucket, '0, FILL_OUT_W'(SLOTS));
              state  <= S_IDLE;
            end else begin
              fvalid[bkt] <= 1'b1;
              nfill       <= f_wdata;
              if (fill_now == '0) begin
                done   <= 1'b1;
                result <= make_res(ST_DONE, cur.value, cur.bucket, '0, FILL_OUT_W'(1));
                state  <= S_IDLE;
              end else begin
                idx   <= fill_now;
                state <= S_SHIFT;
              end
            end
          end else begin
            if (slot_out) begin
              done   <= 1'b1;
              result <= make_res(ST_EMPTY, '0, cur.bucket, cur.slot, FILL_OUT_W'(fill_now));
              state  <= S_IDLE;
            end else begin
              nfill <= fill_now;
              state <= S_RDATA;
            end
          end
        end
        S_RDATA: begin
          done   <= 1'b1;
          result <= make_res(ST_DONE, s_rd, cur.bucket, cur.slot, FILL_OUT_W'(nfill));
          state  <= S_IDLE;
        end
        S_SHIFT: begin
          // The entry below is smaller: the new value lands here.
          if (greater) begin
            done   <= 1'b1;
            result <= make_res(ST_DONE, cur.value, cur.bucket, SLOT_W'(idx),
                               FILL_OUT_W'(nfill));
            state  <= S_IDLE;
          end else if (idx == FW'(1)) begin
            idx   <= '0;
            state <= S_PLACE;
          end else begin
            idx <= idx - FW'(1);
          end
        end
        S_PLACE: begin
          done   <= 1'b1;
          result <= make_res(ST_DONE, cur.value, cur.bucket, '0, FILL_OUT_W'(nfill));
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A dropped insert always reports a full bucket.
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.bucket_fill == FILL_OUT_W'(SLOTS))
    else $error("full status without a full bucket");

  // An empty read never carries a value.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_EMPTY |-> result.result_value == '0)
    else $error("empty read returned a value");

  // The shift index stays above zero and below the slot count, in a non-full row.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (idx != '0) && (idx < FW'(SLOTS)))
    else $error("shift index out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/chained_hash_sorted_buckets_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_sorted_buckets_core: hash store with sorted fixed-size buckets
// The front accepts one item at a time and stays busy until it has queued it;
// an insert first passes the four-bit-per-cycle remainder unit. The queue lets
// the front run ahead of the back, which shifts one slot per cycle through the
// slot RAM port while it sorts an insert into its row.
// Reset clears the fill valid bits, the queue and sets the bucket count to 16;
// the slot RAM is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module chained_hash_sorted_buckets_core #(
  parameter int BUCKETS = chb_pkg::BUCKETS_DEF,
  parameter int SLOTS   = chb_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  chb_pkg::in_item_t         request,
  output logic                      busy,
  input  logic                      cfg_we,
  input  logic [chb_pkg::CFG_W-1:0] cfg_data,
  output logic                      done,
  output chb_pkg::out_item_t        result
);

  import chb_pkg::*;

  logic [CFG_W-1:0] bucket_count;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  op_t              q_in;
  op_t              q_out;

  // Bucket count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  chb_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .bucket_count (bucket_count),
    .busy         (busy),
    .q_push       (q_push),
    .q_op         (q_in),
    .q_full       (q_full)
  );

  chb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  chb_back #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_out),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire
